@@ rtl/dfh_pkg.sv @@
// package for the fixed-huffman deflate token encoder
// token kinds, length and distance code tables, code helper functions
// no dependencies
package dfh_pkg;

    localparam int LEN_CODES  = 29;
    localparam int DIST_SYM_CNT = 30;

    typedef enum logic [1:0] {
        CMD_LITERAL  = 2'd0,
        CMD_MATCH    = 2'd1,
        CMD_END      = 2'd2,
        CMD_RESERVED = 2'd3
    } cmd_t;

    localparam logic [8:0]  LEN_MIN  = 9'd3;
    localparam logic [8:0]  LEN_MAX  = 9'd258;
    localparam logic [15:0] DIST_MIN = 16'd1;
    localparam logic [15:0] DIST_MAX = 16'd32768;

    localparam logic [7:0] LIT_SHORT_MAX = 8'd143;
    localparam logic [8:0] LIT_SHORT_OFS = 9'h030;
    localparam logic [8:0] LIT_LONG_OFS  = 9'h190;
    localparam logic [8:0] LIT_LONG_BASE = 9'd144;
    localparam logic [8:0] EOB_CODE      = 9'd0;
    localparam logic [8:0] LEN_HIGH_OFS  = 9'h0c0;
    localparam logic [4:0] LEN_HIGH_IDX  = 5'd23;
    localparam logic [3:0] NBITS_7       = 4'd7;
    localparam logic [3:0] NBITS_8       = 4'd8;
    localparam logic [3:0] NBITS_9       = 4'd9;
    localparam logic [2:0] DIST_CODE_BITS = 3'd5;

    localparam logic [8:0] LEN_BASE [LEN_CODES] = '{
        9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
        9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
        9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
    };
    localparam logic [2:0] LEN_EXTRA [LEN_CODES] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd0
    };
    localparam logic [15:0] DIST_BASE [DIST_SYM_CNT] = '{
        16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17, 16'd25,
        16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257, 16'd385,
        16'd513, 16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073, 16'd4097,
        16'd6145, 16'd8193, 16'd12289, 16'd16385, 16'd24577
    };
    localparam logic [3:0] DIST_EXTRA [DIST_SYM_CNT] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
        4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
        4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
    };

    typedef struct packed {
        logic [15:0] match_distance;
        logic [8:0]  match_length;
        logic [7:0]  literal_byte;
    } token_t;

    typedef struct packed {
        logic [3:0]  dist_extra_count;
        logic [12:0] dist_extra_bits;
        logic [2:0]  dist_bit_count;
        logic [4:0]  dist_bits;
        logic [2:0]  len_extra_count;
        logic [4:0]  len_extra_bits;
        logic [3:0]  sym_bit_count;
        logic [8:0]  sym_bits;
    } code_t;

    function automatic logic [4:0] len_code_index(input logic [8:0] len);
        logic [4:0] idx;
        idx = '0;
        for (int i = 1; i < LEN_CODES; i++) begin
            if (LEN_BASE[i] <= len) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [4:0] dist_code_index(input logic [15:0] distance);
        logic [4:0] idx;
        idx = '0;
        for (int i = 1; i < DIST_SYM_CNT; i++) begin
            if (DIST_BASE[i] <= distance) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    // code sits in the low nbits, result is those bits mirrored
    function automatic logic [8:0] rev_code(input logic [8:0] code, input logic [3:0] nbits);
        logic [8:0] r;
        for (int i = 0; i < 9; i++) begin
            r[i] = code[8-i];
        end
        return r >> (NBITS_9 - nbits);
    endfunction

    function automatic logic [4:0] rev5(input logic [4:0] v);
        return {v[0], v[1], v[2], v[3], v[4]};
    endfunction

endpackage

@@ rtl/deflate_fixed_huffman_token_encoder.sv @@
// fixed-huffman deflate token encoder, top level
// maps literal, match and end-of-block tokens to reversed code fields
// depends on dfh_pkg
//
// input channel s_*: one token per transaction, s_tuser carries the token kind
// (0 literal, 1 match, 2 end of block), s_tdata the literal, length and distance.
// result channel m_*: one result per token in the same order, m_tdata carries the
// code fields, m_tuser flags a token that cannot be encoded (bad length, bad
// distance or unused kind); all code fields are zero then.
// path: one input register and one result register with the code tables between
// them; the result register loads from the input register when it is empty or its
// result is being taken.
// throughput: one token per cycle while m_tready stays high, set by the single
// register stage pair; the input register can still take one token while a result waits for m_tready.
// when the receiver stalls, the result register holds; once the input register
// also holds a token, s_tready drops; no token is lost or repeated.
// reset (aresetn low at a clock edge) empties both registers; the block has no
// other state and no configuration.
module deflate_fixed_huffman_token_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // literal_byte, match_length, match_distance, zero fill
    input  logic [39:0] s_tdata,
    // cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // sym_bits, sym_bit_count, len_extra_bits, len_extra_count, dist_bits,
    // dist_bit_count, dist_extra_bits, dist_extra_count, zero fill
    output logic [47:0] m_tdata,
    // invalid
    output logic [0:0]  m_tuser
);

    logic             in_valid_reg;
    dfh_pkg::cmd_t    in_cmd_reg;
    dfh_pkg::token_t  in_tok_reg;
    logic             out_valid_reg;
    dfh_pkg::code_t   out_code_reg;
    logic             out_inv_reg;

    logic             advance;
    logic             in_load;
    dfh_pkg::code_t   code_next;
    logic             inv_next;

    assign advance  = !out_valid_reg || m_tready;
    assign in_load  = !in_valid_reg || advance;
    assign s_tready = in_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_load) begin
            in_valid_reg <= s_tvalid;
        end
        if (in_load && s_tvalid) begin
            in_cmd_reg <= dfh_pkg::cmd_t'(s_tuser);
            in_tok_reg <= dfh_pkg::token_t'(s_tdata[32:0]);
        end
    end

    always_comb begin
        logic [8:0]  len;
        logic [15:0] distance;
        logic [4:0]  li;
        logic [4:0]  di;
        logic [8:0]  code;
        logic [3:0]  nbits;
        logic [8:0]  len_diff;
        logic [15:0] dist_diff;
        len       = in_tok_reg.match_length;
        distance  = in_tok_reg.match_distance;
        li        = dfh_pkg::len_code_index(len);
        di        = dfh_pkg::dist_code_index(distance);
        len_diff  = len - dfh_pkg::LEN_BASE[li];
        dist_diff = distance - dfh_pkg::DIST_BASE[di];
        code      = dfh_pkg::EOB_CODE;
        nbits     = dfh_pkg::NBITS_7;
        code_next = '0;
        inv_next  = 1'b0;
        case (in_cmd_reg)
            dfh_pkg::CMD_LITERAL: begin
                if (in_tok_reg.literal_byte <= dfh_pkg::LIT_SHORT_MAX) begin
                    code  = dfh_pkg::LIT_SHORT_OFS + {1'b0, in_tok_reg.literal_byte};
                    nbits = dfh_pkg::NBITS_8;
                end else begin
                    code  = dfh_pkg::LIT_LONG_OFS + {1'b0, in_tok_reg.literal_byte}
                            - dfh_pkg::LIT_LONG_BASE;
                    nbits = dfh_pkg::NBITS_9;
                end
                code_next.sym_bits      = dfh_pkg::rev_code(code, nbits);
                code_next.sym_bit_count = nbits;
            end
            dfh_pkg::CMD_END: begin
                code_next.sym_bits      = dfh_pkg::rev_code(code, nbits);
                code_next.sym_bit_count = nbits;
            end
            dfh_pkg::CMD_MATCH: begin
                if (len < dfh_pkg::LEN_MIN || len > dfh_pkg::LEN_MAX
                        || distance < dfh_pkg::DIST_MIN
                        || distance > dfh_pkg::DIST_MAX) begin
                    inv_next = 1'b1;
                end else begin
                    if (li < dfh_pkg::LEN_HIGH_IDX) begin
                        code  = {4'd0, li} + 9'd1;
                        nbits = dfh_pkg::NBITS_7;
                    end else begin
                        code  = dfh_pkg::LEN_HIGH_OFS + {4'd0, li - dfh_pkg::LEN_HIGH_IDX};
                        nbits = dfh_pkg::NBITS_8;
                    end
                    code_next.sym_bits         = dfh_pkg::rev_code(code, nbits);
                    code_next.sym_bit_count    = nbits;
                    code_next.len_extra_bits   = len_diff[4:0];
                    code_next.len_extra_count  = dfh_pkg::LEN_EXTRA[li];
                    code_next.dist_bits        = dfh_pkg::rev5(di);
                    code_next.dist_bit_count   = dfh_pkg::DIST_CODE_BITS;
                    code_next.dist_extra_bits  = dist_diff[12:0];
                    code_next.dist_extra_count = dfh_pkg::DIST_EXTRA[di];
                end
            end
            default: begin
                inv_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
        if (advance && in_valid_reg) begin
            out_code_reg <= code_next;
            out_inv_reg  <= inv_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_code_reg};
    assign m_tuser  = out_inv_reg;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid && !in_valid_reg)
        else $error("pipeline not empty after reset");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("invalid result carries code fields");

    a_sym_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> (m_tdata[12:9] == 4'd7 || m_tdata[12:9] == 4'd8
                                     || m_tdata[12:9] == 4'd9))
        else $error("symbol size out of range");

    a_match_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[28:26] == dfh_pkg::DIST_CODE_BITS |-> m_tdata[12:9] != 4'd9)
        else $error("match carries a literal-sized code");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled while a stage is free");

endmodule

@@ test/tb.sv @@
// testbench for the fixed-huffman deflate token encoder
// predicts every result with its own tables and compares it field by field
// depends on dfh_pkg and deflate_fixed_huffman_token_encoder
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_TOKENS = 1000;
    localparam int TAIL_TOKENS   = 120;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 200;

    typedef struct {
        dfh_pkg::cmd_t   kind;
        dfh_pkg::token_t tok;
    } token_item_t;

    typedef struct {
        dfh_pkg::code_t fields;
        logic           bad;
    } huff_code_t;

    localparam int LEN_BASE_T [29] = '{
        3, 4, 5, 6, 7, 8, 9, 10, 11, 13, 15, 17, 19, 23, 27, 31,
        35, 43, 51, 59, 67, 83, 99, 115, 131, 163, 195, 227, 258
    };
    localparam int LEN_XTRA_T [29] = '{
        0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 2,
        3, 3, 3, 3, 4, 4, 4, 4, 5, 5, 5, 5, 0
    };
    localparam int DIST_BASE_T [30] = '{
        1, 2, 3, 4, 5, 7, 9, 13, 17, 25, 33, 49, 65, 97, 129, 193,
        257, 385, 513, 769, 1025, 1537, 2049, 3073, 4097, 6145,
        8193, 12289, 16385, 24577
    };
    localparam int DIST_XTRA_T [30] = '{
        0, 0, 0, 0, 1, 1, 2, 2, 3, 3, 4, 4, 5, 5, 6, 6,
        7, 7, 8, 8, 9, 9, 10, 10, 11, 11, 12, 12, 13, 13
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;

    token_item_t token_q[$];
    huff_code_t  expected_codes[$];
    token_item_t nxt;
    huff_code_t  want;
    logic        s_taken;
    int          send_gap;
    int          recv_hold;
    logic        long_hold_done;
    int          errors;
    int          results_seen;
    int          n_literal;
    int          n_match;
    int          n_end;
    int          n_bad;

    deflate_fixed_huffman_token_encoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    function automatic huff_code_t encode_token(input dfh_pkg::cmd_t kind,
                                                input dfh_pkg::token_t tok);
        huff_code_t r;
        int         sym;
        int         li;
        int         di;
        logic [8:0] code;
        int         nbits;
        r.fields = '0;
        r.bad = 1'b0;
        li = 0;
        di = 0;
        if (kind == dfh_pkg::CMD_LITERAL) begin
            sym = tok.literal_byte;
        end else if (kind == dfh_pkg::CMD_END) begin
            sym = 256;
        end else if (kind != dfh_pkg::CMD_MATCH || tok.match_length < dfh_pkg::LEN_MIN
                     || tok.match_length > dfh_pkg::LEN_MAX
                     || tok.match_distance < dfh_pkg::DIST_MIN
                     || tok.match_distance > dfh_pkg::DIST_MAX) begin
            r.bad = 1'b1;
            return r;
        end else begin
            for (int i = 1; i < 29; i++) begin
                if (LEN_BASE_T[i] <= tok.match_length) li = i;
            end
            for (int i = 1; i < 30; i++) begin
                if (DIST_BASE_T[i] <= tok.match_distance) di = i;
            end
            sym = 257 + li;
            r.fields.len_extra_bits   = 5'(tok.match_length - LEN_BASE_T[li]);
            r.fields.len_extra_count  = 3'(LEN_XTRA_T[li]);
            for (int i = 0; i < 5; i++) r.fields.dist_bits[i] = di[4 - i];
            r.fields.dist_bit_count   = 3'd5;
            r.fields.dist_extra_bits  = 13'(tok.match_distance - DIST_BASE_T[di]);
            r.fields.dist_extra_count = 4'(DIST_XTRA_T[di]);
        end
        if (sym <= 143) begin
            code = 9'(48 + sym);
            nbits = 8;
        end else if (sym <= 255) begin
            code = 9'(400 + sym - 144);
            nbits = 9;
        end else if (sym <= 279) begin
            code = 9'(sym - 256);
            nbits = 7;
        end else begin
            code = 9'(192 + sym - 280);
            nbits = 8;
        end
        for (int i = 0; i < 9; i++) begin
            if (i < nbits) r.fields.sym_bits[i] = code[nbits - 1 - i];
        end
        r.fields.sym_bit_count = 4'(nbits);
        return r;
    endfunction

    task automatic queue_token(input dfh_pkg::cmd_t kind, input int lit, input int len,
                               input int distance);
        token_item_t t;
        t.kind = kind;
        t.tok.literal_byte = 8'(lit);
        t.tok.match_length = 9'(len);
        t.tok.match_distance = 16'(distance);
        token_q = {token_q, t};
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic check_result(input huff_code_t w);
        dfh_pkg::code_t got;
        got = dfh_pkg::code_t'(m_tdata[45:0]);
        check_field("sym_bits", w.fields.sym_bits, got.sym_bits);
        check_field("sym_bit_count", w.fields.sym_bit_count, got.sym_bit_count);
        check_field("len_extra_bits", w.fields.len_extra_bits, got.len_extra_bits);
        check_field("len_extra_count", w.fields.len_extra_count, got.len_extra_count);
        check_field("dist_bits", w.fields.dist_bits, got.dist_bits);
        check_field("dist_bit_count", w.fields.dist_bit_count, got.dist_bit_count);
        check_field("dist_extra_bits", w.fields.dist_extra_bits, got.dist_extra_bits);
        check_field("dist_extra_count", w.fields.dist_extra_count, got.dist_extra_count);
        check_field("tdata fill", 0, m_tdata[47:46]);
        check_field("invalid", w.bad, m_tuser[0]);
    endtask

    // token source
    always @(negedge aclk) begin
        if (aresetn !== 1'b1) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (token_q.size() > 0) begin
                nxt = token_q.pop_front();
                s_tuser <= nxt.kind;
                s_tdata <= {7'd0, nxt.tok};
                s_tvalid <= 1'b1;
                if (token_q.size() > TAIL_TOKENS && $urandom_range(0, 4) == 0) begin
                    send_gap = $urandom_range(1, 11);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result sink with random stalls and one long hold-off
    always @(negedge aclk) begin
        if (aresetn !== 1'b1) begin
            m_tready <= 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold = recv_hold - 1;
            m_tready <= 1'b0;
        end else if (!long_hold_done && results_seen >= HOLD_AT) begin
            long_hold_done = 1'b1;
            recv_hold = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (token_q.size() > TAIL_TOKENS && $urandom_range(0, 5) == 0) begin
            recv_hold = $urandom_range(0, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor: predict on each accepted token, check each accepted result
    always @(posedge aclk) begin
        s_taken = aresetn && s_tvalid && s_tready;
        if (s_taken) begin
            want = encode_token(dfh_pkg::cmd_t'(s_tuser), dfh_pkg::token_t'(s_tdata[32:0]));
            expected_codes = {expected_codes, want};
            if (want.bad) n_bad++;
            else if (s_tuser == dfh_pkg::CMD_LITERAL) n_literal++;
            else if (s_tuser == dfh_pkg::CMD_MATCH) n_match++;
            else n_end++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_codes.size() == 0) begin
                $display("%0t ns: unexpected result, expected none actual tdata %h tuser %b",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                check_result(expected_codes.pop_front());
            end
        end
    end

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int r;
        int lit;
        int len;
        int distance;
        int idx;
        dfh_pkg::cmd_t kind;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        s_taken = 1'b0;
        send_gap = 0;
        recv_hold = 0;
        long_hold_done = 1'b0;
        errors = 0;
        results_seen = 0;
        n_literal = 0;
        n_match = 0;
        n_end = 0;
        n_bad = 0;

        // field extremes, code boundaries and every unencodable case
        queue_token(dfh_pkg::CMD_LITERAL, 0, 0, 0);
        queue_token(dfh_pkg::CMD_LITERAL, 143, 511, 65535);
        queue_token(dfh_pkg::CMD_LITERAL, 144, 0, 0);
        queue_token(dfh_pkg::CMD_LITERAL, 255, 511, 65535);
        queue_token(dfh_pkg::CMD_END, 0, 0, 0);
        queue_token(dfh_pkg::CMD_END, 255, 511, 65535);
        queue_token(dfh_pkg::CMD_MATCH, 255, 3, 1);
        queue_token(dfh_pkg::CMD_MATCH, 0, 258, 32768);
        queue_token(dfh_pkg::CMD_MATCH, 0, 257, 24577);
        queue_token(dfh_pkg::CMD_MATCH, 0, 10, 4);
        queue_token(dfh_pkg::CMD_MATCH, 0, 11, 5);
        queue_token(dfh_pkg::CMD_MATCH, 0, 227, 16384);
        queue_token(dfh_pkg::CMD_MATCH, 0, 162, 8192);
        queue_token(dfh_pkg::CMD_MATCH, 0, 256, 24576);
        queue_token(dfh_pkg::CMD_MATCH, 0, 2, 1);
        queue_token(dfh_pkg::CMD_MATCH, 0, 259, 1);
        queue_token(dfh_pkg::CMD_MATCH, 0, 0, 100);
        queue_token(dfh_pkg::CMD_MATCH, 0, 511, 100);
        queue_token(dfh_pkg::CMD_MATCH, 0, 100, 0);
        queue_token(dfh_pkg::CMD_MATCH, 0, 100, 32769);
        queue_token(dfh_pkg::CMD_MATCH, 0, 100, 65535);
        queue_token(dfh_pkg::CMD_RESERVED, 0, 0, 0);
        queue_token(dfh_pkg::CMD_RESERVED, 200, 50, 50);
        queue_token(dfh_pkg::CMD_LITERAL, 8'haa, 9'h155, 16'h5555);

        for (int n = 0; n < RANDOM_TOKENS; n++) begin
            r = $urandom_range(0, 99);
            lit = $urandom_range(0, 255);
            len = $urandom_range(0, 511);
            distance = $urandom_range(0, 65535);
            if (r < 35) begin
                kind = dfh_pkg::CMD_LITERAL;
            end else if (r < 80) begin
                kind = dfh_pkg::CMD_MATCH;
                idx = $urandom_range(0, 28);
                len = LEN_BASE_T[idx] + $urandom_range(0, (1 << LEN_XTRA_T[idx]) - 1);
                if (len > 258) len = 258;
                idx = $urandom_range(0, 29);
                distance = DIST_BASE_T[idx] + $urandom_range(0, (1 << DIST_XTRA_T[idx]) - 1);
            end else if (r < 88) begin
                kind = dfh_pkg::CMD_END;
            end else begin
                kind = dfh_pkg::CMD_MATCH;
                case ($urandom_range(0, 3))
                    0: begin
                        kind = dfh_pkg::CMD_RESERVED;
                    end
                    1: begin
                        len = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2)
                                                          : $urandom_range(259, 511);
                        distance = $urandom_range(1, 32768);
                    end
                    2: begin
                        len = $urandom_range(3, 258);
                        distance = ($urandom_range(0, 1) != 0) ? 0
                                                               : $urandom_range(32769, 65535);
                    end
                    default: begin
                    end
                endcase
            end
            queue_token(kind, lit, len, distance);
        end

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (token_q.size() != 0 || s_tvalid || expected_codes.size() != 0);
        repeat (10) @(posedge aclk);

        $display("tokens: %0d literal, %0d match, %0d end of block, %0d unencodable",
                 n_literal, n_match, n_end, n_bad);
        $display("results checked: %0d, mismatches: %0d", results_seen, errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/dfh_pkg.sv
rtl/deflate_fixed_huffman_token_encoder.sv
test/tb.sv
